>>> design/cdate_pkg.sv
// Shared types, constants and calendar table functions for the date arithmetic block.
package cdate_pkg;

    // Request kinds
    localparam logic [1:0] KIND_ADD_YEARS  = 2'd0;
    localparam logic [1:0] KIND_ADD_MONTHS = 2'd1;
    localparam logic [1:0] KIND_ADD_DAYS   = 2'd2;
    localparam logic [1:0] KIND_DIFF       = 2'd3;

    localparam logic [13:0] YEAR_MIN = 14'd1600;
    localparam logic [13:0] YEAR_MAX = 14'd16383;

    // Day numbers of Jan 1 of the first valid year and of the year past the range
    localparam logic signed [24:0] COUNT_LO = 25'sd584387;
    localparam logic signed [24:0] COUNT_HI = 25'sd5984128;

    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
    localparam logic [6:0] HUNDRED       = 7'd100;
    localparam logic [5:0] FORTY         = 6'd40;
    localparam logic [3:0] TWELVE        = 4'd12;

    // Reciprocals: x/100 = x*5243>>19 (x < 16384), x/40 = x*205>>13 (x < 164),
    // x/3 = x*2796203>>23 (x < 2^22)
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [7:0]  RECIP_40  = 8'd205;
    localparam logic [21:0] RECIP_3   = 22'd2796203;

    // Year estimate: (day number * 2^24 * 4000 / 1460969) >> 24
    localparam logic [15:0] YEAR_RECIP = 16'd45935;

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_START = 15'b000000000000010,
        ST_U1    = 15'b000000000000100,
        ST_U2    = 15'b000000000001000,
        ST_U3    = 15'b000000000010000,
        ST_EVAL  = 15'b000000000100000,
        ST_K1A   = 15'b000000001000000,
        ST_K1B   = 15'b000000010000000,
        ST_K1C   = 15'b000000100000000,
        ST_K2A   = 15'b000001000000000,
        ST_K2B   = 15'b000010000000000,
        ST_K2C   = 15'b000100000000000,
        ST_DIFF  = 15'b001000000000000,
        ST_MD    = 15'b010000000000000,
        ST_DONE  = 15'b100000000000000
    } state_t;

    // What the year unit result is used for
    typedef enum logic [1:0] {
        PH_BASE   = 2'd0,
        PH_RES    = 2'd1,
        PH_OTHER  = 2'd2,
        PH_SEARCH = 2'd3
    } phase_t;

    // Day of year at the first of month m (0-based), leap day included
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] s;
        case (m)
            4'd1:    s = 9'd0;
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (m > 4'd2) s = s + {8'd0, leap};
        return s;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = 5'd28 + {4'd0, leap};
            default:                                     n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

>>> design/calendar_date_offset_and_difference.sv
// Top level: Gregorian date offset and day difference unit.
//
// Usage:
//   Input channel s_*: one request per transfer (kind, base date, signed
//   offset, second date). s_ready is high only while the unit is idle.
//   Result channel m_*: one result per request, held in an output register
//   until the transfer completes. A new request can be taken while the
//   previous result still waits on m_ready.
// Steps: a base date that fails the first check goes from ST_START to
//   ST_DONE. Others pass the base year through the year unit; then year
//   steps pass the result year, month steps run ST_K1A to ST_K1C and pass
//   the result year, differences pass the second year and run ST_DIFF, day
//   steps run ST_K2A to ST_K2C, then one or two passes find the year of the
//   day number, then ST_MD. Each pass through the shared year unit (day
//   number of Jan 1 and leap status of one year) runs ST_U1 to ST_EVAL.
// Reset (aresetn low, synchronous) returns to idle and drops m_valid.
// A stalled receiver holds the result; the unit finishes the next request
//   up to its last step and waits there until the output register frees.
module calendar_date_offset_and_difference
    import cdate_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [13:0]        s_date_year,
    input  logic [3:0]         s_date_month,
    input  logic [4:0]         s_date_day,
    input  logic signed [23:0] s_offset_amount,
    input  logic [13:0]        s_other_year,
    input  logic [3:0]         s_other_month,
    input  logic [4:0]         s_other_day,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [13:0]        m_result_year,
    output logic [3:0]         m_result_month,
    output logic [4:0]         m_result_day,
    output logic signed [23:0] m_day_difference,
    output logic               m_invalid
);

    // Control
    state_t state_reg, state_next;
    phase_t phase_reg;
    logic   out_valid_reg;

    // Captured request
    logic [1:0]         kind_reg;
    logic [13:0]        y_reg;
    logic [3:0]         m_reg;
    logic [4:0]         d_reg;
    logic signed [23:0] off_reg;
    logic [13:0]        oy_reg;
    logic [3:0]         om_reg;
    logic [4:0]         od_reg;

    // Year unit: n_reg = year - 1
    logic [13:0] n_reg;
    logic [7:0]  q100_reg;
    logic [22:0] p365_reg;
    logic [6:0]  r100_reg;
    logic [2:0]  q40_reg;
    logic [22:0] t_reg;
    logic        leap_reg;
    logic [22:0] dby_reg;

    // Working values
    logic [13:0]        yy_reg;
    logic [22:0]        cnt_reg;
    logic signed [24:0] c_reg;
    logic [19:0]        q_reg;
    logic [14:0]        est_reg;
    logic [8:0]         doy_reg;

    // Result under construction
    logic [13:0]        ry_reg;
    logic [3:0]         rm_reg;
    logic [4:0]         rd_reg;
    logic signed [23:0] diff_reg;
    logic               bad_reg;

    // Output register
    logic [13:0]        out_year_reg;
    logic [3:0]         out_month_reg;
    logic [4:0]         out_day_reg;
    logic signed [23:0] out_diff_reg;
    logic               out_invalid_reg;

    // ---------------- year unit arithmetic ----------------
    logic [26:0] q100_prod;
    logic [22:0] p365_prod;
    logic [15:0] q40_prod;
    logic [13:0] q100_x100;
    logic [13:0] r100_full;
    logic [22:0] t_sum;
    logic [7:0]  r40_full;
    logic        leap_calc;
    logic [22:0] dby_calc;

    assign q100_prod = 27'(n_reg) * 27'(RECIP_100);
    assign p365_prod = 23'(n_reg) * 23'(DAYS_PER_YEAR);
    assign q40_prod  = 16'(q100_reg) * 16'(RECIP_40);
    assign q100_x100 = 14'(q100_reg) * 14'(HUNDRED);
    assign r100_full = n_reg - q100_x100;
    assign t_sum     = p365_reg + 23'(DAYS_PER_YEAR) + 23'(n_reg[13:2]);
    assign r40_full  = q100_reg - 8'(q40_reg) * 8'(FORTY);

    // year = n + 1: century year when n mod 100 is 99; then leap needs
    // (n/100 + 1) divisible by 4 but not by 40
    assign leap_calc = (r100_reg == 7'd99) ?
                       ((q100_reg[1:0] == 2'd3) && (r40_full != 8'd39)) :
                       (n_reg[1:0] == 2'd3);
    assign dby_calc  = t_reg - 23'(q100_reg) + 23'(q100_reg[7:2]) - 23'(q40_reg);

    // ---------------- request checks and sums ----------------
    logic               base_pre_ok;
    logic               other_pre_ok;
    logic               base_day_bad;
    logic               other_day_bad;
    logic               res_day_bad;
    logic [22:0]        base_cnt;
    logic [22:0]        other_cnt;
    logic signed [24:0] off_ext;
    logic signed [24:0] year_sum;
    logic               year_sum_ok;
    logic [17:0]        y_x12;
    logic signed [24:0] month_total;
    logic signed [24:0] day_target;
    logic [43:0]        div3_prod;
    logic [23:0]        q_x12;
    logic [23:0]        rem_full;
    logic               q_ok;
    logic [38:0]        est_prod;
    logic               count_ok;
    logic [13:0]        est_year;
    logic [22:0]        c_low;
    logic [22:0]        next_start;
    logic               search_low;
    logic               search_high;
    logic [22:0]        doy_full;

    assign base_pre_ok  = (y_reg >= YEAR_MIN) && (m_reg >= 4'd1) && (m_reg <= TWELVE) &&
                          (d_reg >= 5'd1) && (d_reg <= month_len(m_reg, 1'b1));
    assign other_pre_ok = (oy_reg >= YEAR_MIN) && (om_reg >= 4'd1) && (om_reg <= TWELVE) &&
                          (od_reg >= 5'd1) && (od_reg <= month_len(om_reg, 1'b1));
    assign base_day_bad  = d_reg  > month_len(m_reg, leap_reg);
    assign other_day_bad = od_reg > month_len(om_reg, leap_reg);
    assign res_day_bad   = rd_reg > month_len(rm_reg, leap_reg);

    assign base_cnt  = dby_reg + 23'(month_start(m_reg, leap_reg)) + 23'(d_reg) - 23'd1;
    assign other_cnt = dby_reg + 23'(month_start(om_reg, leap_reg)) + 23'(od_reg) - 23'd1;

    assign off_ext     = {off_reg[23], off_reg};
    assign year_sum    = $signed({11'd0, y_reg}) + off_ext;
    assign year_sum_ok = (year_sum >= $signed({11'd0, YEAR_MIN})) &&
                         (year_sum <= $signed({11'd0, YEAR_MAX}));

    assign y_x12       = 18'(y_reg) * 18'(TWELVE);
    assign month_total = $signed({7'd0, y_x12}) + $signed({21'd0, m_reg}) - 25'sd1 + off_ext;
    assign day_target  = $signed({2'd0, cnt_reg}) + off_ext;

    // total months / 12 = (total / 4) / 3
    assign div3_prod = 44'(c_reg[23:2]) * 44'(RECIP_3);
    assign q_x12     = 24'(q_reg) * 24'(TWELVE);
    assign rem_full  = c_reg[23:0] - q_x12;
    assign q_ok      = (q_reg >= 20'(YEAR_MIN)) && (q_reg <= 20'(YEAR_MAX));

    assign est_prod  = 39'(c_reg[22:0]) * 39'(YEAR_RECIP);
    assign count_ok  = (c_reg >= COUNT_LO) && (c_reg < COUNT_HI);
    assign est_year  = (est_reg < 15'(YEAR_MIN)) ? YEAR_MIN :
                       (est_reg > 15'(YEAR_MAX)) ? YEAR_MAX : est_reg[13:0];

    // Year search: target must satisfy Jan 1 of yy <= c < Jan 1 of yy + 1
    assign c_low       = c_reg[22:0];
    assign next_start  = dby_reg + 23'(DAYS_PER_YEAR) + 23'(leap_reg);
    assign search_low  = c_low < dby_reg;
    assign search_high = c_low >= next_start;
    assign doy_full    = c_low - dby_reg;

    // Month and day from day of year
    logic [3:0] md_month;
    logic [4:0] md_day;
    logic [8:0] md_start;

    always_comb begin
        md_month = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (doy_reg >= month_start(4'(k), leap_reg)) md_month = 4'(k);
        end
        md_start = month_start(md_month, leap_reg);
        md_day   = 5'(doy_reg - md_start + 9'd1);
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_START;
            ST_START: state_next = base_pre_ok ? ST_U1 : ST_DONE;
            ST_U1:    state_next = ST_U2;
            ST_U2:    state_next = ST_U3;
            ST_U3:    state_next = ST_EVAL;
            ST_EVAL: begin
                case (phase_reg)
                    PH_BASE: begin
                        if (base_day_bad) begin
                            state_next = ST_DONE;
                        end else begin
                            case (kind_reg)
                                KIND_ADD_YEARS:  state_next = year_sum_ok ? ST_U1 : ST_DONE;
                                KIND_ADD_MONTHS: state_next = ST_K1A;
                                KIND_ADD_DAYS:   state_next = ST_K2A;
                                KIND_DIFF:       state_next = other_pre_ok ? ST_U1 : ST_DONE;
                                default:         state_next = ST_DONE;
                            endcase
                        end
                    end
                    PH_RES:    state_next = ST_DONE;
                    PH_OTHER:  state_next = other_day_bad ? ST_DONE : ST_DIFF;
                    PH_SEARCH: state_next = (search_low || search_high) ? ST_U1 : ST_MD;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_K1A:  state_next = ST_K1B;
            ST_K1B:  state_next = c_reg[24] ? ST_DONE : ST_K1C;
            ST_K1C:  state_next = q_ok ? ST_U1 : ST_DONE;
            ST_K2A:  state_next = ST_K2B;
            ST_K2B:  state_next = count_ok ? ST_K2C : ST_DONE;
            ST_K2C:  state_next = ST_U1;
            ST_DIFF: state_next = ST_DONE;
            ST_MD:   state_next = ST_DONE;
            ST_DONE: if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_BASE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_START: phase_reg <= PH_BASE;
                ST_EVAL: begin
                    if (phase_reg == PH_BASE && !base_day_bad) begin
                        if (kind_reg == KIND_DIFF) phase_reg <= PH_OTHER;
                        else                       phase_reg <= PH_RES;
                    end
                end
                ST_K2C:  phase_reg <= PH_SEARCH;
                default: phase_reg <= phase_reg;
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_reg <= s_kind;
                    y_reg    <= s_date_year;
                    m_reg    <= s_date_month;
                    d_reg    <= s_date_day;
                    off_reg  <= s_offset_amount;
                    oy_reg   <= s_other_year;
                    om_reg   <= s_other_month;
                    od_reg   <= s_other_day;
                end
            end
            ST_START: begin
                ry_reg   <= '0;
                rm_reg   <= '0;
                rd_reg   <= '0;
                diff_reg <= '0;
                bad_reg  <= !base_pre_ok;
                n_reg    <= y_reg - 14'd1;
            end
            ST_U1: begin
                q100_reg <= q100_prod[26:19];
                p365_reg <= p365_prod;
            end
            ST_U2: begin
                r100_reg <= r100_full[6:0];
                q40_reg  <= q40_prod[15:13];
                t_reg    <= t_sum;
            end
            ST_U3: begin
                leap_reg <= leap_calc;
                dby_reg  <= dby_calc;
            end
            ST_EVAL: begin
                case (phase_reg)
                    PH_BASE: begin
                        cnt_reg <= base_cnt;
                        if (base_day_bad) begin
                            bad_reg <= 1'b1;
                        end else if (kind_reg == KIND_ADD_YEARS) begin
                            if (year_sum_ok) begin
                                yy_reg <= year_sum[13:0];
                                n_reg  <= year_sum[13:0] - 14'd1;
                                rm_reg <= m_reg;
                                rd_reg <= d_reg;
                            end else begin
                                bad_reg <= 1'b1;
                            end
                        end else if (kind_reg == KIND_DIFF) begin
                            if (other_pre_ok) n_reg   <= oy_reg - 14'd1;
                            else              bad_reg <= 1'b1;
                        end
                    end
                    PH_RES: begin
                        if (res_day_bad) bad_reg <= 1'b1;
                        else             ry_reg  <= yy_reg;
                    end
                    PH_OTHER: begin
                        if (other_day_bad) bad_reg <= 1'b1;
                        else               c_reg   <= $signed({2'd0, other_cnt});
                    end
                    PH_SEARCH: begin
                        if (search_low) begin
                            yy_reg <= yy_reg - 14'd1;
                            n_reg  <= yy_reg - 14'd2;
                        end else if (search_high) begin
                            yy_reg <= yy_reg + 14'd1;
                            n_reg  <= yy_reg;
                        end else begin
                            doy_reg <= doy_full[8:0];
                        end
                    end
                    default: bad_reg <= 1'b1;
                endcase
            end
            ST_K1A: c_reg <= month_total;
            ST_K1B: begin
                if (c_reg[24]) bad_reg <= 1'b1;
                else           q_reg   <= div3_prod[42:23];
            end
            ST_K1C: begin
                if (q_ok) begin
                    yy_reg <= q_reg[13:0];
                    n_reg  <= q_reg[13:0] - 14'd1;
                    rm_reg <= rem_full[3:0] + 4'd1;
                    rd_reg <= d_reg;
                end else begin
                    bad_reg <= 1'b1;
                end
            end
            ST_K2A: c_reg <= day_target;
            ST_K2B: begin
                if (count_ok) est_reg <= est_prod[38:24];
                else          bad_reg <= 1'b1;
            end
            ST_K2C: begin
                yy_reg <= est_year;
                n_reg  <= est_year - 14'd1;
            end
            // Both day numbers lie below 2^23, so the difference always fits
            ST_DIFF: diff_reg <= $signed({1'b0, cnt_reg}) - $signed({1'b0, c_reg[22:0]});
            ST_MD: begin
                ry_reg <= yy_reg;
                rm_reg <= md_month;
                rd_reg <= md_day;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_year_reg    <= bad_reg ? '0 : ry_reg;
                    out_month_reg   <= bad_reg ? '0 : rm_reg;
                    out_day_reg     <= bad_reg ? '0 : rd_reg;
                    out_diff_reg    <= bad_reg ? '0 : diff_reg;
                    out_invalid_reg <= bad_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = out_valid_reg;
    assign m_result_year    = out_year_reg;
    assign m_result_month   = out_month_reg;
    assign m_result_day     = out_day_reg;
    assign m_day_difference = out_diff_reg;
    assign m_invalid        = out_invalid_reg;

`ifndef ASSERT_OFF
    // A request is worked on before another is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken on consecutive cycles");

    // Flagged results carry no date and no difference
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_invalid) |-> (m_result_year == 14'd0 && m_result_month == 4'd0 &&
                                    m_result_day == 5'd0 && m_day_difference == 24'sd0))
        else $error("invalid result with nonzero fields");

    // A returned date is in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_invalid && m_result_month != 4'd0) |->
        (m_result_year >= YEAR_MIN && m_result_month <= TWELVE && m_result_day != 5'd0 &&
         m_day_difference == 24'sd0))
        else $error("returned date out of range");

    // The year unit only ever sees years of the valid range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_U1) |-> (n_reg >= YEAR_MIN - 14'd1 && n_reg <= YEAR_MAX - 14'd1))
        else $error("year unit started outside the year range");
`endif

endmodule

>>> sim/testbench.sv
// Testbench for the Gregorian date offset and day difference unit.
`timescale 1ns / 100ps

module testbench;
    import cdate_pkg::*;

    // One request as it goes over the input channel
    typedef struct packed {
        logic [1:0]         kind;
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic signed [23:0] offset;
        logic [13:0]        o_year;
        logic [3:0]         o_month;
        logic [4:0]         o_day;
    } date_req_t;

    // One result as it comes back on the result channel
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [23:0] diff;
        logic        invalid;
    } date_res_t;

    logic               aclk;
    logic               aresetn          = 1'b0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [1:0]         s_kind           = '0;
    logic [13:0]        s_date_year      = '0;
    logic [3:0]         s_date_month     = '0;
    logic [4:0]         s_date_day       = '0;
    logic signed [23:0] s_offset_amount  = '0;
    logic [13:0]        s_other_year     = '0;
    logic [3:0]         s_other_month    = '0;
    logic [4:0]         s_other_day      = '0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [13:0]        m_result_year;
    logic [3:0]         m_result_month;
    logic [4:0]         m_result_day;
    logic signed [23:0] m_day_difference;
    logic               m_invalid;

    // Results predicted at acceptance, oldest first
    date_res_t pending_results[$];
    date_res_t oldest_result;
    int        errors     = 0;
    // Chance in percent that a transfer is preceded / a cycle starts a stall burst
    int        idle_pct   = 25;
    int        stall_pct  = 20;
    int        stall_left = 0;

    calendar_date_offset_and_difference i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_date_year      (s_date_year),
        .s_date_month     (s_date_month),
        .s_date_day       (s_date_day),
        .s_offset_amount  (s_offset_amount),
        .s_other_year     (s_other_year),
        .s_other_month    (s_other_month),
        .s_other_day      (s_other_day),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_year    (m_result_year),
        .m_result_month   (m_result_month),
        .m_result_day     (m_result_day),
        .m_day_difference (m_day_difference),
        .m_invalid        (m_invalid)
    );

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    // 4/100/400/4000 rule: multiples of 4000 are common years
    function automatic bit leap_year(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || ((y % 400 == 0) && (y % 4000 != 0));
    endfunction

    function automatic longint month_days(input longint y, input longint m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Day of year of the first of month m, zero based
    function automatic longint days_before_month(input longint m, input bit lp);
        longint n;
        case (m)
            2:       n = 31;
            3:       n = 59;
            4:       n = 90;
            5:       n = 120;
            6:       n = 151;
            7:       n = 181;
            8:       n = 212;
            9:       n = 243;
            10:      n = 273;
            11:      n = 304;
            12:      n = 334;
            default: n = 0;
        endcase
        return (m > 2) ? n + lp : n;
    endfunction

    function automatic bit date_valid(input longint y, input longint m, input longint d);
        if (y < longint'(YEAR_MIN) || y > longint'(YEAR_MAX)) return 1'b0;
        if (m < 1 || m > 12) return 1'b0;
        return (d >= 1) && (d <= month_days(y, m));
    endfunction

    // Day number of Jan 1 of year y, counted from year 0
    function automatic longint year_start(input longint y);
        longint p;
        p = y - 1;
        return y * 365 + p / 4 - p / 100 + p / 400 - p / 4000;
    endfunction

    function automatic longint day_number(input longint y, input longint m, input longint d);
        return year_start(y) + days_before_month(m, leap_year(y)) + d - 1;
    endfunction

    // Back from a day number; 0 when it falls outside the legal year span
    function automatic bit day_number_to_date(input longint c, output longint y,
                                              output longint m, output longint d);
        longint yy;
        longint doy;
        longint mm;
        bit     lp;
        y = 0;
        m = 0;
        d = 0;
        if (c < year_start(longint'(YEAR_MIN)) || c >= year_start(longint'(YEAR_MAX) + 1))
            return 1'b0;
        yy = c * 4000 / 1460969;
        if (yy < longint'(YEAR_MIN)) yy = longint'(YEAR_MIN);
        if (yy > longint'(YEAR_MAX)) yy = longint'(YEAR_MAX);
        while (yy > longint'(YEAR_MIN) && year_start(yy) > c) yy--;
        while (yy < longint'(YEAR_MAX) && year_start(yy + 1) <= c) yy++;
        doy = c - year_start(yy);
        lp  = leap_year(yy);
        mm  = 12;
        while (mm > 1 && doy < days_before_month(mm, lp)) mm--;
        y = yy;
        m = mm;
        d = doy - days_before_month(mm, lp) + 1;
        return 1'b1;
    endfunction

    // Expected result for one request
    function automatic date_res_t compute_date_result(input date_req_t r);
        longint    y, m, d, off, ry, rm, rd, diff, total;
        bit        bad;
        date_res_t res;
        y    = r.year;
        m    = r.month;
        d    = r.day;
        off  = longint'($signed(r.offset));
        ry   = 0;
        rm   = 0;
        rd   = 0;
        diff = 0;
        bad  = 1'b0;
        if (!date_valid(y, m, d)) begin
            bad = 1'b1;
        end else begin
            case (r.kind)
                KIND_ADD_YEARS: begin
                    ry  = y + off;
                    rm  = m;
                    rd  = d;
                    bad = !date_valid(ry, rm, rd);
                end
                KIND_ADD_MONTHS: begin
                    total = y * 12 + m - 1 + off;
                    if (total < 0) begin
                        bad = 1'b1;
                    end else begin
                        ry  = total / 12;
                        rm  = total % 12 + 1;
                        rd  = d;
                        bad = !date_valid(ry, rm, rd);
                    end
                end
                KIND_ADD_DAYS: begin
                    bad = !day_number_to_date(day_number(y, m, d) + off, ry, rm, rd);
                end
                default: begin
                    if (!date_valid(r.o_year, r.o_month, r.o_day)) begin
                        bad = 1'b1;
                    end else begin
                        diff = day_number(y, m, d) - day_number(r.o_year, r.o_month, r.o_day);
                        if (diff > 8388607)  diff = 8388607;
                        if (diff < -8388608) diff = -8388608;
                    end
                end
            endcase
        end
        if (bad) begin
            ry   = 0;
            rm   = 0;
            rd   = 0;
            diff = 0;
        end
        res.year    = ry[13:0];
        res.month   = rm[3:0];
        res.day     = rd[4:0];
        res.diff    = diff[23:0];
        res.invalid = bad;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Timeout well past the worst correct run
    initial begin
        #5000000;
        $display("[calendar_date_offset_and_difference] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: m_ready dropped for random bursts of stall cycles
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 13);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Every completed result transfer is checked against the oldest prediction.
    // Values read here are the ones sampled at this edge (NBAs not yet applied).
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result transfer with nothing expected, expected none actual %0d/%0d/%0d",
                         $time, m_result_year, m_result_month, m_result_day);
            end else begin
                oldest_result = pending_results.pop_front();
                compare_field("result_year", oldest_result.year, m_result_year);
                compare_field("result_month", oldest_result.month, m_result_month);
                compare_field("result_day", oldest_result.day, m_result_day);
                compare_field("day_difference", longint'($signed(oldest_result.diff)),
                              longint'(m_day_difference));
                compare_field("invalid", oldest_result.invalid, m_invalid);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drives one request and holds it until the transfer. Valid is only
    // dropped ahead of an idle burst, so back-to-back requests keep it high.
    task automatic send_request(input date_req_t r);
        int gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= r.kind;
        s_date_year     <= r.year;
        s_date_month    <= r.month;
        s_date_day      <= r.day;
        s_offset_amount <= r.offset;
        s_other_year    <= r.o_year;
        s_other_month   <= r.o_month;
        s_other_day     <= r.o_day;
        do @(posedge aclk); while (!s_ready);
        pending_results.insert(pending_results.size(), compute_date_result(r));
    endtask

    task automatic issue(input logic [1:0] k, input int y, input int m, input int d,
                         input int off, input int oy = 0, input int om = 0, input int od = 0);
        date_req_t r;
        r.kind    = k;
        r.year    = y[13:0];
        r.month   = m[3:0];
        r.day     = d[4:0];
        r.offset  = off[23:0];
        r.o_year  = oy[13:0];
        r.o_month = om[3:0];
        r.o_day   = od[4:0];
        send_request(r);
    endtask

    // Legal date, leaning toward the range ends, century and 4000-year boundaries
    // and month ends; now and then an arbitrary (often illegal) one
    task automatic pick_date(output int y, output int m, output int d);
        int len;
        case ($urandom_range(0, 9))
            0:       y = $urandom_range(1600, 1700);
            1:       y = $urandom_range(16283, 16383);
            2:       y = 100 * $urandom_range(16, 163);
            3:       y = 4000 * $urandom_range(1, 4) - $urandom_range(0, 4);
            default: y = $urandom_range(1600, 16383);
        endcase
        m   = $urandom_range(1, 12);
        len = int'(month_days(y, m));
        d   = ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
        if ($urandom_range(0, 11) == 0) begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
    endtask

    function automatic int signed_span(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int full_offset();
        logic [31:0] rnd;
        rnd = $urandom();
        return int'($signed(rnd[23:0]));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, each kind, and special cases
    task automatic test_directed();
        issue(KIND_ADD_YEARS, 1599, 1, 1, 1);                 // base before 1600
        issue(KIND_DIFF, 2000, 15, 31, 0, 2000, 1, 1);        // base month out of range
        issue(KIND_ADD_DAYS, 2000, 4, 31, 1);                 // day missing in base month
        issue(KIND_ADD_MONTHS, 2000, 1, 0, 1);                // day zero
        issue(KIND_ADD_YEARS, 1900, 2, 29, 0);                // century is common
        issue(KIND_ADD_YEARS, 4000, 2, 29, 0);                // 4000 is common
        issue(KIND_ADD_YEARS, 2000, 5, 15, 0);                // zero offset
        issue(KIND_ADD_DAYS, 16383, 12, 31, 0);               // zero offset at top
        issue(KIND_ADD_DAYS, 16383, 12, 31, 1);               // past the year range
        issue(KIND_ADD_DAYS, 1600, 1, 1, -1);                 // before 1600
        issue(KIND_ADD_DAYS, 1600, 1, 1, 5399740);            // lands on last legal day
        issue(KIND_ADD_DAYS, 2000, 1, 1, 8388607);
        issue(KIND_ADD_DAYS, 16383, 12, 31, -8388608);
        issue(KIND_ADD_DAYS, 2000, 2, 28, 1);                 // into leap day
        issue(KIND_ADD_DAYS, 3999, 12, 31, 60);               // across a common 4000
        issue(KIND_ADD_YEARS, 2000, 2, 29, 1);                // leap day gone
        issue(KIND_ADD_YEARS, 2000, 2, 29, 400);
        issue(KIND_ADD_YEARS, 2000, 2, 29, 2000);             // into 4000
        issue(KIND_ADD_YEARS, 16383, 12, 31, -14783);         // down to 1600
        issue(KIND_ADD_MONTHS, 2001, 1, 31, 1);               // Feb 31
        issue(KIND_ADD_MONTHS, 1600, 1, 1, -1);
        issue(KIND_ADD_MONTHS, 2000, 5, 15, -8388608);        // month total negative
        issue(KIND_ADD_MONTHS, 2000, 5, 15, 8388607);
        issue(KIND_DIFF, 16383, 12, 31, 0, 1600, 1, 1);       // widest span both ways
        issue(KIND_DIFF, 1600, 1, 1, -1, 16383, 12, 31);
        issue(KIND_DIFF, 2000, 3, 1, 0, 2000, 2, 29);
        issue(KIND_DIFF, 2000, 1, 1, 0, 2000, 2, 30);         // second date illegal
        issue(KIND_DIFF, 2000, 1, 1, 0, 2000, 0, 1);
    endtask

    task automatic test_year_steps(input int count);
        int y, m, d, off;
        repeat (count) begin
            pick_date(y, m, d);
            case ($urandom_range(0, 5))
                0:       off = signed_span(50);
                1:       off = signed_span(16000);
                2:       off = full_offset();
                3:       off = 1600 - y - $urandom_range(0, 1);
                4:       off = 16383 - y + $urandom_range(0, 1);
                default: off = signed_span(3000);
            endcase
            issue(KIND_ADD_YEARS, y, m, d, off, $urandom_range(0, 16383),
                  $urandom_range(0, 15), $urandom_range(0, 31));
        end
    endtask

    task automatic test_month_steps(input int count);
        int y, m, d, off;
        repeat (count) begin
            pick_date(y, m, d);
            case ($urandom_range(0, 4))
                0:       off = signed_span(24);
                1:       off = signed_span(180000);
                2:       off = full_offset();
                3:       off = (1600 - y) * 12 - $urandom_range(0, 13);
                default: off = signed_span(1200);
            endcase
            issue(KIND_ADD_MONTHS, y, m, d, off, $urandom_range(0, 16383),
                  $urandom_range(0, 15), $urandom_range(0, 31));
        end
    endtask

    task automatic test_day_steps(input int count);
        int y, m, d, off;
        repeat (count) begin
            pick_date(y, m, d);
            case ($urandom_range(0, 4))
                0:       off = signed_span(400);
                1:       off = signed_span(60000);
                2:       off = signed_span(5400000);
                3:       off = full_offset();
                default: off = signed_span(3000);
            endcase
            issue(KIND_ADD_DAYS, y, m, d, off, $urandom_range(0, 16383),
                  $urandom_range(0, 15), $urandom_range(0, 31));
        end
    endtask

    task automatic test_differences(input int count);
        int y, m, d, oy, om, od;
        repeat (count) begin
            pick_date(y, m, d);
            pick_date(oy, om, od);
            // identical pairs now and then, to see zero differences
            if ($urandom_range(0, 3) == 0) begin
                oy = y;
                om = m;
                od = d;
            end
            issue(KIND_DIFF, y, m, d, full_offset(), oy, om, od);
        end
    endtask

    // Arbitrary field values, any kind
    task automatic test_malformed_requests(input int count);
        repeat (count) begin
            issue(2'($urandom_range(0, 3)), $urandom_range(0, 16383), $urandom_range(0, 15),
                  $urandom_range(0, 31), full_offset(), $urandom_range(0, 16383),
                  $urandom_range(0, 15), $urandom_range(0, 31));
        end
    endtask

    // Mixed kinds with no idling on either side
    task automatic test_back_to_back(input int count);
        idle_pct  = 0;
        stall_pct = 0;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0:       test_year_steps(1);
                1:       test_month_steps(1);
                2:       test_day_steps(1);
                default: test_differences(1);
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_year_steps(220);
        idle_pct  = 5;
        stall_pct = 5;
        test_month_steps(220);
        idle_pct  = 40;
        stall_pct = 30;
        test_day_steps(360);
        idle_pct  = 15;
        stall_pct = 10;
        test_differences(220);
        test_malformed_requests(110);
        test_back_to_back(120);

        // let the last results drain, then a margin past the longest latency
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        if (errors == 0) begin
            $display("[calendar_date_offset_and_difference] OK");
        end else begin
            $display("[calendar_date_offset_and_difference] ERROR");
        end
        $finish;
    end

endmodule
